### rtl/core/lscs_pkg.sv
// ----------------------------------------------------------------------------
// LED strip cascade sequencer package
// Shared widths, codes, job and strip config types, LED index helpers.
// ----------------------------------------------------------------------------
package lscs_pkg;

  localparam int NUM_STRIPS_DEF     = 4;
  localparam int MAX_STRIP_LEDS_DEF = 1024;
  localparam int MAX_STRIPS         = 4;

  localparam int CFG_IDX_W   = 3;
  localparam int STRIP_CFG_W = 22;
  localparam int PERIOD_W    = 16;
  localparam int TOTAL_W     = 11;
  localparam int COUNT_W     = 11;
  localparam int OFFSET_W    = 10;
  localparam int STEP_W      = 12;
  localparam int IDX_W       = 14;
  localparam int LED_W       = 10;
  localparam int COLOR_W     = 24;
  localparam int BRIGHT_W    = 8;
  localparam int MODE_W      = 3;
  localparam int OP_W        = 2;
  localparam int STRIP_IDX_W = 2;
  localparam int IN_DATA_W   = 32;
  localparam int OUT_DATA_W  = 48;

  localparam logic [PERIOD_W-1:0] STEP_PERIOD_RST = 16'd20;
  localparam logic [TOTAL_W-1:0]  TOTAL_STEPS_RST = 11'd1024;
  localparam logic [COLOR_W-1:0]  WHITE           = 24'hFFFFFF;
  localparam logic [BRIGHT_W-1:0] FULL_BRIGHT     = 8'd255;

  localparam logic [CFG_IDX_W-1:0] REG_STEP_PERIOD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_STEPS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STRIP_BASE  = 3'd2;

  localparam logic [MODE_W-1:0] MODE_OFF     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PWR_ON  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ON      = 3'd2;
  localparam logic [MODE_W-1:0] MODE_PWR_OFF = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CHG     = 3'd4;

  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 2'd0,
    OP_OPEN  = 2'd1,
    OP_CLOSE = 2'd2,
    OP_COLOR = 2'd3
  } op_t;

  typedef struct packed {
    logic [COUNT_W-1:0]  count;
    logic [OFFSET_W-1:0] offset;
    logic                en;
  } strip_cfg_t;

  typedef struct packed {
    logic [MAX_STRIPS-1:0]    mask;
    logic signed [STEP_W-1:0] step;
    logic                     erase;
    logic [COLOR_W-1:0]       color;
    logic [BRIGHT_W-1:0]      bright;
    logic [MODE_W-1:0]        mode;
    logic                     power;
  } job_t;

  function automatic logic [COUNT_W-1:0] clamp_count(strip_cfg_t c,
                                                     logic [COUNT_W-1:0] max_leds);
    return (c.count > max_leds) ? max_leds : c.count;
  endfunction

  function automatic logic signed [IDX_W-1:0] led_idx(strip_cfg_t c,
                                                      logic signed [STEP_W-1:0] step,
                                                      logic [TOTAL_W-1:0] total,
                                                      logic erase,
                                                      logic [COUNT_W-1:0] max_leds);
    logic signed [IDX_W-1:0] step_x;
    logic signed [IDX_W-1:0] cnt_x;
    step_x = {{(IDX_W-STEP_W){step[STEP_W-1]}}, step};
    cnt_x  = $signed({{(IDX_W-COUNT_W){1'b0}}, clamp_count(c, max_leds)});
    if (erase) begin
      return cnt_x - $signed({{(IDX_W-TOTAL_W){1'b0}}, total}) + step_x;
    end else begin
      return step_x - $signed({{(IDX_W-OFFSET_W){1'b0}}, c.offset});
    end
  endfunction

  function automatic logic led_hit(strip_cfg_t c, logic signed [IDX_W-1:0] idx,
                                   logic [COUNT_W-1:0] max_leds);
    logic signed [IDX_W-1:0] cnt_x;
    cnt_x = $signed({{(IDX_W-COUNT_W){1'b0}}, clamp_count(c, max_leds)});
    return c.en && !idx[IDX_W-1] && (idx < cnt_x);
  endfunction

endpackage

### rtl/core/led_strip_cascade_sequencer_top.sv
// ----------------------------------------------------------------------------
// LED strip cascade sequencer
// Front end sequences modes and steps; pixel writer streams the writes.
// ----------------------------------------------------------------------------
// A command or tick word is taken by the front end. A tick that lands a
// cascade step queues one job when the step hits a strip; the pixel writer
// loads the job and then sends one word per hit strip, one per cycle while
// the output is not stalled. The first word of a step passes through the job
// queue, the writer's job register and the output register. s_tready drops
// only while the two-entry job queue is full. cfg_ready is always high; write
// config only while idle.
module led_strip_cascade_sequencer_top #(
  parameter int NUM_STRIPS     = lscs_pkg::NUM_STRIPS_DEF,
  parameter int MAX_STRIP_LEDS = lscs_pkg::MAX_STRIP_LEDS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [lscs_pkg::IN_DATA_W-1:0]      s_tdata,   // new_color, new_brightness
  input  logic [lscs_pkg::OP_W-1:0]           s_tuser,   // op
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // strip_index, led_index, pixel_color, brightness, mode, power_on
  output logic [lscs_pkg::OUT_DATA_W-1:0]     m_tdata,
  output logic                                m_tlast,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lscs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lscs_pkg::STRIP_CFG_W-1:0]    cfg_data
);

  lscs_pkg::strip_cfg_t             strip_cfg [NUM_STRIPS];
  logic [lscs_pkg::TOTAL_W-1:0]     total_steps;
  logic                             job_push;
  lscs_pkg::job_t                   push_job;
  logic                             job_full;
  logic                             job_pop;
  lscs_pkg::job_t                   head_job;
  logic                             job_valid;

  assign cfg_ready = 1'b1;

  lscs_front #(
    .NUM_STRIPS     (NUM_STRIPS),
    .MAX_STRIP_LEDS (MAX_STRIP_LEDS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_op       (lscs_pkg::op_t'(s_tuser)),
    .in_color    (s_tdata[lscs_pkg::COLOR_W-1:0]),
    .in_bright   (s_tdata[lscs_pkg::COLOR_W +: lscs_pkg::BRIGHT_W]),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .strip_cfg   (strip_cfg),
    .total_steps (total_steps),
    .job_push    (job_push),
    .job         (push_job),
    .job_full    (job_full)
  );

  lscs_job_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (job_push),
    .push_job  (push_job),
    .full      (job_full),
    .pop       (job_pop),
    .head      (head_job),
    .not_empty (job_valid)
  );

  lscs_back #(
    .NUM_STRIPS     (NUM_STRIPS),
    .MAX_STRIP_LEDS (MAX_STRIP_LEDS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .job_valid   (job_valid),
    .job         (head_job),
    .job_pop     (job_pop),
    .strip_cfg   (strip_cfg),
    .total_steps (total_steps),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_data    (m_tdata),
    .out_last    (m_tlast)
  );

endmodule

### rtl/core/lscs_front.sv
// ----------------------------------------------------------------------------
// Sequencer front end
// Holds config and sequencer state, takes commands and ticks, queues steps.
// ----------------------------------------------------------------------------
module lscs_front #(
  parameter int NUM_STRIPS     = lscs_pkg::NUM_STRIPS_DEF,
  parameter int MAX_STRIP_LEDS = lscs_pkg::MAX_STRIP_LEDS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  lscs_pkg::op_t                        in_op,
  input  logic [lscs_pkg::COLOR_W-1:0]         in_color,
  input  logic [lscs_pkg::BRIGHT_W-1:0]        in_bright,
  input  logic                                 cfg_valid,
  input  logic [lscs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lscs_pkg::STRIP_CFG_W-1:0]     cfg_data,
  output lscs_pkg::strip_cfg_t                 strip_cfg [NUM_STRIPS],
  output logic [lscs_pkg::TOTAL_W-1:0]         total_steps,
  output logic                                 job_push,
  output lscs_pkg::job_t                       job,
  input  logic                                 job_full
);

  typedef enum logic [4:0] {
    ST_OFF     = 5'b00001,
    ST_PWR_ON  = 5'b00010,
    ST_ON      = 5'b00100,
    ST_PWR_OFF = 5'b01000,
    ST_CHG     = 5'b10000
  } mode_state_t;

  localparam logic [lscs_pkg::COUNT_W-1:0] MAX_LEDS = lscs_pkg::COUNT_W'(MAX_STRIP_LEDS);
  localparam logic signed [lscs_pkg::STEP_W-1:0] STEP_ONE = lscs_pkg::STEP_W'(1);

  logic [lscs_pkg::PERIOD_W-1:0]    step_period;
  mode_state_t                      mode, mode_next;
  logic signed [lscs_pkg::STEP_W-1:0] step, step_next;
  logic [lscs_pkg::PERIOD_W-1:0]    elapsed, elapsed_next;
  logic [lscs_pkg::COLOR_W-1:0]     cur_color, cur_color_next;
  logic [lscs_pkg::BRIGHT_W-1:0]    cur_bright, cur_bright_next;
  logic [lscs_pkg::COLOR_W-1:0]     q_color, q_color_next;
  logic [lscs_pkg::BRIGHT_W-1:0]    q_bright, q_bright_next;
  logic                             power, power_next;

  logic                             accept;
  logic                             erase_now;
  logic [NUM_STRIPS-1:0]            hit_mask;
  logic [lscs_pkg::PERIOD_W-1:0]    elapsed_inc;
  logic signed [lscs_pkg::STEP_W-1:0] close_step;
  logic signed [lscs_pkg::STEP_W-1:0] total_x;
  logic [lscs_pkg::MODE_W-1:0]      mode_code;
  logic                             animating;

  assign in_ready = !job_full;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_period <= lscs_pkg::STEP_PERIOD_RST;
      total_steps <= lscs_pkg::TOTAL_STEPS_RST;
      for (int s = 0; s < NUM_STRIPS; s++) begin
        strip_cfg[s] <= '0;
      end
    end else if (cfg_valid) begin
      if (cfg_index == lscs_pkg::REG_STEP_PERIOD) begin
        step_period <= cfg_data[lscs_pkg::PERIOD_W-1:0];
      end else if (cfg_index == lscs_pkg::REG_TOTAL_STEPS) begin
        total_steps <= cfg_data[lscs_pkg::TOTAL_W-1:0];
      end
      for (int s = 0; s < NUM_STRIPS; s++) begin
        if (cfg_index == lscs_pkg::REG_STRIP_BASE + lscs_pkg::CFG_IDX_W'(s)) begin
          strip_cfg[s] <= cfg_data;
        end
      end
    end
  end

  always_comb begin
    unique case (mode)
      ST_OFF:     mode_code = lscs_pkg::MODE_OFF;
      ST_PWR_ON:  mode_code = lscs_pkg::MODE_PWR_ON;
      ST_ON:      mode_code = lscs_pkg::MODE_ON;
      ST_PWR_OFF: mode_code = lscs_pkg::MODE_PWR_OFF;
      ST_CHG:     mode_code = lscs_pkg::MODE_CHG;
      default:    mode_code = lscs_pkg::MODE_OFF;
    endcase
  end

  assign erase_now   = (mode != ST_PWR_ON);
  assign animating   = (mode == ST_PWR_ON) || (mode == ST_PWR_OFF) || (mode == ST_CHG);
  assign elapsed_inc = (elapsed == '1) ? elapsed : elapsed + 1'b1;
  assign total_x     = $signed({1'b0, total_steps});
  assign close_step  = total_x - STEP_ONE;

  always_comb begin
    for (int s = 0; s < NUM_STRIPS; s++) begin
      hit_mask[s] = lscs_pkg::led_hit(strip_cfg[s],
                      lscs_pkg::led_idx(strip_cfg[s], step, total_steps, erase_now, MAX_LEDS),
                      MAX_LEDS);
    end
  end

  always_comb begin
    mode_next       = mode;
    step_next       = step;
    elapsed_next    = elapsed;
    cur_color_next  = cur_color;
    cur_bright_next = cur_bright;
    q_color_next    = q_color;
    q_bright_next   = q_bright;
    power_next      = power;
    job_push        = 1'b0;
    job             = '0;
    job.mask[NUM_STRIPS-1:0] = hit_mask;
    job.step        = step;
    job.erase       = erase_now;
    job.color       = erase_now ? '0 : cur_color;
    job.bright      = cur_bright;
    job.mode        = mode_code;
    job.power       = power;
    if (accept) begin
      unique case (in_op)
        lscs_pkg::OP_OPEN: begin
          step_next  = '0;
          mode_next  = ST_PWR_ON;
          power_next = 1'b1;
        end
        lscs_pkg::OP_CLOSE: begin
          step_next  = close_step;
          mode_next  = ST_PWR_OFF;
          power_next = 1'b0;
        end
        lscs_pkg::OP_COLOR: begin
          q_color_next  = in_color;
          q_bright_next = in_bright;
          step_next     = close_step;
          mode_next     = ST_CHG;
        end
        lscs_pkg::OP_TICK: begin
          elapsed_next = elapsed_inc;
          if (animating && (elapsed_inc >= step_period)) begin
            elapsed_next = '0;
            unique case (mode)
              ST_PWR_ON: begin
                if (step < total_x) begin
                  job_push  = |hit_mask;
                  step_next = step + STEP_ONE;
                end else begin
                  mode_next = ST_ON;
                end
              end
              ST_PWR_OFF: begin
                if (!step[lscs_pkg::STEP_W-1]) begin
                  job_push  = |hit_mask;
                  step_next = step - STEP_ONE;
                end else begin
                  mode_next = ST_OFF;
                end
              end
              ST_CHG: begin
                if (!step[lscs_pkg::STEP_W-1]) begin
                  job_push  = |hit_mask;
                  step_next = step - STEP_ONE;
                end else begin
                  cur_color_next  = q_color;
                  cur_bright_next = q_bright;
                  step_next       = '0;
                  mode_next       = ST_PWR_ON;
                end
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= ST_OFF;
      step       <= '0;
      elapsed    <= '0;
      cur_color  <= lscs_pkg::WHITE;
      cur_bright <= lscs_pkg::FULL_BRIGHT;
      q_color    <= lscs_pkg::WHITE;
      q_bright   <= lscs_pkg::FULL_BRIGHT;
      power      <= 1'b0;
    end else begin
      mode       <= mode_next;
      step       <= step_next;
      elapsed    <= elapsed_next;
      cur_color  <= cur_color_next;
      cur_bright <= cur_bright_next;
      q_color    <= q_color_next;
      q_bright   <= q_bright_next;
      power      <= power_next;
    end
  end

endmodule

### rtl/core/lscs_job_queue.sv
// ----------------------------------------------------------------------------
// Step job queue
// Two-entry queue of step jobs between front end and pixel writer.
// ----------------------------------------------------------------------------
module lscs_job_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lscs_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output lscs_pkg::job_t head,
  output logic           not_empty
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);

  lscs_pkg::job_t       mem [DEPTH];
  logic [PTR_W-1:0]     wr_ptr;
  logic [PTR_W-1:0]     rd_ptr;
  logic [PTR_W:0]       count;

  assign full      = (count == (PTR_W+1)'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && not_empty) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      priority if ((push && !full) && !(pop && not_empty)) begin
        count <= count + 1'b1;
      end else if (!(push && !full) && (pop && not_empty)) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/core/lscs_back.sv
// ----------------------------------------------------------------------------
// Pixel writer
// Walks the hit strips of a step job, one pixel write word per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module lscs_back #(
  parameter int NUM_STRIPS     = lscs_pkg::NUM_STRIPS_DEF,
  parameter int MAX_STRIP_LEDS = lscs_pkg::MAX_STRIP_LEDS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              job_valid,
  input  lscs_pkg::job_t                    job,
  output logic                              job_pop,
  input  lscs_pkg::strip_cfg_t              strip_cfg [NUM_STRIPS],
  input  logic [lscs_pkg::TOTAL_W-1:0]      total_steps,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [lscs_pkg::OUT_DATA_W-1:0]   out_data,
  output logic                              out_last
);

  localparam int SW = (NUM_STRIPS > 1) ? $clog2(NUM_STRIPS) : 1;
  localparam logic [lscs_pkg::COUNT_W-1:0] MAX_LEDS = lscs_pkg::COUNT_W'(MAX_STRIP_LEDS);

  logic                               busy;
  lscs_pkg::job_t                     cur;
  logic [NUM_STRIPS-1:0]              rem;
  logic [NUM_STRIPS-1:0]              rem_after;
  logic [SW-1:0]                      sel;
  logic signed [lscs_pkg::IDX_W-1:0]  idx;
  logic                               emit;

  always_comb begin
    sel = '0;
    for (int s = NUM_STRIPS - 1; s >= 0; s--) begin
      if (rem[s]) begin
        sel = SW'(s);
      end
    end
    rem_after      = rem;
    rem_after[sel] = 1'b0;
  end

  assign idx     = lscs_pkg::led_idx(strip_cfg[sel], cur.step, total_steps, cur.erase, MAX_LEDS);
  assign emit    = busy && (!out_valid || out_ready);
  assign job_pop = !busy && job_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (job_pop) begin
        busy <= 1'b1;
      end else if (emit) begin
        busy <= |rem_after;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      cur <= job;
      rem <= job.mask[NUM_STRIPS-1:0];
    end else if (emit) begin
      rem <= rem_after;
    end
    if (emit) begin
      out_data <= {cur.power, cur.mode, cur.bright, cur.color,
                   idx[lscs_pkg::LED_W-1:0], lscs_pkg::STRIP_IDX_W'(sel)};
      out_last <= !(|rem_after);
    end
  end

endmodule

### rtl/core/lscs_checker.sv
// ----------------------------------------------------------------------------
// Sequencer port checker
// Port-level checks on the pixel write stream, bound to the top level.
// ----------------------------------------------------------------------------
module lscs_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [lscs_pkg::OUT_DATA_W-1:0]   m_tdata,
  input logic                              m_tlast
);

  logic [lscs_pkg::MODE_W-1:0] out_mode;
  assign out_mode = m_tdata[46:44];

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("pixel word changed while stalled");

  a_anim_mode: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_mode == lscs_pkg::MODE_PWR_ON) || (out_mode == lscs_pkg::MODE_PWR_OFF) ||
                 (out_mode == lscs_pkg::MODE_CHG))
    else $error("pixel write outside an animating mode");

  a_erase_black: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (out_mode == lscs_pkg::MODE_PWR_OFF) |-> (m_tdata[35:12] == '0) && !m_tdata[47])
    else $error("power-off write not black or power flag set");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

endmodule

bind led_strip_cascade_sequencer_top lscs_checker u_lscs_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

### tb/led_strip_cascade_sequencer_top_tb.sv
// ----------------------------------------------------------------------------
// LED strip cascade sequencer testbench
// Drives tick and command words with bursty input and stalling output, keeps
// its own model of modes, cascade position and colors, and checks every
// pixel write field by field against the predicted order.
// ----------------------------------------------------------------------------
module led_strip_cascade_sequencer_top_tb;
  import lscs_pkg::*;

  localparam int LIMIT_CYCLES  = 200000;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 400;
  localparam int ELAPSED_MAX   = 65535;
  localparam int RANDOM_WORDS  = 100;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = REG_STRIP_BASE + 3'(NUM_STRIPS_DEF);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = REG_SPARE_LO + 3'd1;

  typedef struct {
    logic [STRIP_IDX_W-1:0] strip;
    logic [LED_W-1:0]       led;
    logic [COLOR_W-1:0]     color;
    logic [BRIGHT_W-1:0]    bright;
    logic [MODE_W-1:0]      mode;
    logic                   power;
    logic                   last;
  } pixel_write_t;

  typedef struct {
    logic [CFG_IDX_W-1:0]   index;
    logic [STRIP_CFG_W-1:0] data;
  } reg_write_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;   // new_color, new_brightness
  logic [OP_W-1:0] s_tuser = '0;        // op
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;       // strip_index, led_index, pixel_color, brightness,
                                        // mode, power_on
  logic m_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [STRIP_CFG_W-1:0] cfg_data = '0;

  led_strip_cascade_sequencer_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // sequencer model
  int           period_cfg;
  int           total_cfg;
  strip_cfg_t   strip_cfg [NUM_STRIPS_DEF];
  logic [MODE_W-1:0] seq_mode;
  int           cascade_pos;
  int           elapsed;
  logic [COLOR_W-1:0]  cur_color;
  logic [BRIGHT_W-1:0] cur_bright;
  logic [COLOR_W-1:0]  next_color;
  logic [BRIGHT_W-1:0] next_bright;
  logic         power_flag;

  pixel_write_t expected_pixels[$];
  reg_write_t   reg_queue[$];
  int error_count = 0;

  bit gaps_on = 1'b1;
  int burst_left = 0;
  int hold_requests = 0;

  function automatic void reset_model();
    period_cfg = int'(STEP_PERIOD_RST);
    total_cfg = int'(TOTAL_STEPS_RST);
    foreach (strip_cfg[i]) strip_cfg[i] = '0;
    seq_mode = MODE_OFF;
    cascade_pos = 0;
    elapsed = 0;
    cur_color = WHITE;
    cur_bright = FULL_BRIGHT;
    next_color = WHITE;
    next_bright = FULL_BRIGHT;
    power_flag = 1'b0;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] index, logic [STRIP_CFG_W-1:0] data);
    if (index == REG_STEP_PERIOD) period_cfg = int'(data[PERIOD_W-1:0]);
    else if (index == REG_TOTAL_STEPS) total_cfg = int'(data[TOTAL_W-1:0]);
    else if (index >= REG_STRIP_BASE && index < REG_SPARE_LO)
      strip_cfg[index - REG_STRIP_BASE] = data;
  endfunction

  function automatic void cascade_step_writes(bit erase);
    pixel_write_t w;
    int cnt;
    int idx;
    int n;
    n = 0;
    for (int s = 0; s < NUM_STRIPS_DEF; s++) begin
      if (!strip_cfg[s].en) continue;
      cnt = (int'(strip_cfg[s].count) > MAX_STRIP_LEDS_DEF) ? MAX_STRIP_LEDS_DEF :
            int'(strip_cfg[s].count);
      idx = erase ? cnt - total_cfg + cascade_pos : cascade_pos - int'(strip_cfg[s].offset);
      if (idx < 0 || idx >= cnt) continue;
      w.strip = STRIP_IDX_W'(s);
      w.led = LED_W'(idx);
      w.color = erase ? '0 : cur_color;
      w.bright = cur_bright;
      w.mode = seq_mode;
      w.power = power_flag;
      w.last = 1'b0;
      expected_pixels.push_back(w);
      n++;
    end
    if (n > 0) expected_pixels[$].last = 1'b1;
  endfunction

  function automatic void advance_sequencer(op_t op, logic [COLOR_W-1:0] color,
                                            logic [BRIGHT_W-1:0] bright);
    case (op)
      OP_OPEN: begin
        cascade_pos = 0;
        seq_mode = MODE_PWR_ON;
        power_flag = 1'b1;
      end
      OP_CLOSE: begin
        cascade_pos = total_cfg - 1;
        seq_mode = MODE_PWR_OFF;
        power_flag = 1'b0;
      end
      OP_COLOR: begin
        next_color = color;
        next_bright = bright;
        cascade_pos = total_cfg - 1;
        seq_mode = MODE_CHG;
      end
      default: begin
        if (elapsed < ELAPSED_MAX) elapsed++;
        if (seq_mode != MODE_OFF && seq_mode != MODE_ON && elapsed >= period_cfg) begin
          elapsed = 0;
          if (seq_mode == MODE_PWR_ON) begin
            if (cascade_pos < total_cfg) begin
              cascade_step_writes(1'b0);
              cascade_pos++;
            end else begin
              seq_mode = MODE_ON;
            end
          end else if (cascade_pos >= 0) begin
            cascade_step_writes(1'b1);
            cascade_pos--;
          end else if (seq_mode == MODE_PWR_OFF) begin
            seq_mode = MODE_OFF;
          end else begin
            cur_color = next_color;
            cur_bright = next_bright;
            cascade_pos = 0;
            seq_mode = MODE_PWR_ON;
          end
        end
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [OUT_DATA_W-1:0] got,
                                 input logic [OUT_DATA_W-1:0] want);
    if (error_count < 100)
      $display("ERROR %s: got %0h expected %0h", what, got, want);
    error_count++;
  endtask

  // output check
  always @(posedge clk) begin : check_pixel
    pixel_write_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("unexpected word", m_tdata, '0);
      end else begin
        want = expected_pixels.pop_front();
        if (m_tdata[1:0] !== want.strip) report_mismatch("strip_index", m_tdata[1:0], want.strip);
        if (m_tdata[11:2] !== want.led) report_mismatch("led_index", m_tdata[11:2], want.led);
        if (m_tdata[35:12] !== want.color)
          report_mismatch("pixel_color", m_tdata[35:12], want.color);
        if (m_tdata[43:36] !== want.bright)
          report_mismatch("brightness", m_tdata[43:36], want.bright);
        if (m_tdata[46:44] !== want.mode) report_mismatch("mode", m_tdata[46:44], want.mode);
        if (m_tdata[47] !== want.power) report_mismatch("power_on", m_tdata[47], want.power);
        if (m_tlast !== want.last) report_mismatch("last", m_tlast, want.last);
      end
    end
  end

  // output stall pattern and long hold-off
  logic [7:0] ready_pattern = 8'hFF;
  int pattern_left = 0;
  int pattern_pos = 0;
  int hold_left = 0;
  int hold_seen = 0;

  always @(posedge clk) begin
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_requests) begin
      hold_seen <= hold_requests;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else begin
      if (pattern_left == 0) begin
        ready_pattern <= ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
        pattern_left <= $urandom_range(16, 96);
      end else begin
        pattern_left <= pattern_left - 1;
      end
      pattern_pos <= pattern_pos + 1;
      m_tready <= ready_pattern[pattern_pos % 8];
    end
  end

  int cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("led_strip_cascade_sequencer_top_tb: FAIL");
      $finish;
    end
  end

  task automatic send_word(input op_t op, input logic [COLOR_W-1:0] color,
                           input logic [BRIGHT_W-1:0] bright);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(1, 6);
      burst_left = $urandom_range(1, 16);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {bright, color};
    do @(posedge clk); while (!s_tready);
    advance_sequencer(op, color, bright);
    if (burst_left > 0) burst_left--;
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_word(OP_TICK, 24'($urandom), 8'($urandom));
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_push(input logic [CFG_IDX_W-1:0] index, input logic [STRIP_CFG_W-1:0] data);
    reg_write_t w;
    w.index = index;
    w.data = data;
    reg_queue.push_back(w);
  endtask

  task automatic cfg_flush();
    reg_write_t w;
    while (reg_queue.size() > 0) begin
      w = reg_queue.pop_front();
      cfg_valid <= 1'b1;
      cfg_index <= w.index;
      cfg_data <= w.data;
      do @(posedge clk); while (!cfg_ready);
      apply_reg(w.index, w.data);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic set_timing(input int period, input int total);
    cfg_push(REG_STEP_PERIOD, {6'($urandom), 16'(period)});
    cfg_push(REG_TOTAL_STEPS, {11'($urandom), 11'(total)});
  endtask

  task automatic set_strips(input strip_cfg_t s0, input strip_cfg_t s1,
                            input strip_cfg_t s2, input strip_cfg_t s3);
    cfg_push(REG_STRIP_BASE, s0);
    cfg_push(REG_STRIP_BASE + 3'd1, s1);
    cfg_push(REG_STRIP_BASE + 3'd2, s2);
    cfg_push(REG_STRIP_BASE + 3'd3, s3);
  endtask

  // reset period and total, white at full brightness
  task automatic test_defaults();
    cfg_push(REG_STRIP_BASE, strip_cfg_t'{count: 11'd3, offset: 10'd0, en: 1'b1});
    cfg_flush();
    send_ticks(19);
    send_word(OP_OPEN, '0, '0);
    send_ticks(1);
    wait_idle();
  endtask

  // every command in several modes, disabled strip, unused indexes ignored
  task automatic test_commands();
    set_timing(0, 6);
    set_strips('{count: 11'd3, offset: 10'd0, en: 1'b1}, '{count: 11'd4, offset: 10'd2, en: 1'b1},
               '{count: 11'd5, offset: 10'd0, en: 1'b0}, '{count: 11'd1, offset: 10'd5, en: 1'b1});
    cfg_push(REG_SPARE_LO, 22'h3FFFFF);
    cfg_push(REG_SPARE_HI, 22'h3FFFFF);
    cfg_flush();
    send_word(OP_OPEN, '0, '0);
    send_ticks(9);
    send_word(OP_CLOSE, 24'hFFFFFF, 8'hFF);
    send_ticks(3);
    send_word(OP_OPEN, '0, '0);
    send_ticks(2);
    send_word(OP_COLOR, 24'h000000, 8'h00);
    send_ticks(16);
    send_word(OP_COLOR, 24'hFFFFFF, 8'hFF);
    send_ticks(16);
    wait_idle();
  endtask

  // zero total steps: erase ends at once, power-on ends at once
  task automatic test_zero_total();
    set_timing(0, 0);
    cfg_flush();
    send_word(OP_CLOSE, '0, '0);
    send_ticks(2);
    send_word(OP_COLOR, 24'h5A5AA5, 8'h3C);
    send_ticks(3);
    send_word(OP_OPEN, '0, '0);
    send_ticks(2);
    wait_idle();
  endtask

  // step period of zero, then above zero with ticks between steps
  task automatic test_step_period();
    set_timing(0, 2);
    set_strips('{count: 11'd2, offset: 10'd0, en: 1'b1}, '0, '0, '0);
    cfg_flush();
    send_word(OP_OPEN, '0, '0);
    send_ticks(4);
    wait_idle();
    set_timing(7, 3);
    cfg_flush();
    send_word(OP_COLOR, 24'h123456, 8'h40);
    send_ticks(40);
    wait_idle();
  endtask

  // largest total, full-length strips and oversized count clamp
  task automatic test_long_cascade();
    set_timing(0, 2047);
    set_strips('{count: 11'd1024, offset: 10'd1023, en: 1'b1},
               '{count: 11'd2047, offset: 10'd0, en: 1'b1},
               '{count: 11'd1023, offset: 10'd1023, en: 1'b1},
               '{count: 11'd0, offset: 10'd5, en: 1'b1});
    cfg_flush();
    send_word(OP_OPEN, 24'h0F1E2D, 8'h80);
    send_ticks(6);
    send_word(OP_CLOSE, '0, '0);
    send_ticks(8);
    wait_idle();
  endtask

  // long output hold-off while ticks keep coming
  task automatic test_backpressure();
    set_timing(0, 30);
    set_strips('{count: 11'd20, offset: 10'd0, en: 1'b1}, '{count: 11'd20, offset: 10'd1, en: 1'b1},
               '{count: 11'd20, offset: 10'd2, en: 1'b1}, '{count: 11'd20, offset: 10'd3, en: 1'b1});
    cfg_flush();
    send_word(OP_OPEN, '0, '0);
    wait_idle();
    hold_requests <= hold_requests + 1;
    gaps_on = 1'b0;
    send_ticks(40);
    gaps_on = 1'b1;
    wait_idle();
  endtask

  task automatic test_random_traffic();
    strip_cfg_t sc [NUM_STRIPS_DEF];
    int sent;
    int period;
    int total;
    int n;
    op_t op;
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      wait_idle();
      period = ($urandom_range(0, 4) < 3) ? 0 : $urandom_range(1, 3);
      total = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
      foreach (sc[i]) begin
        sc[i].en = ($urandom_range(0, 3) != 0);
        sc[i].offset = OFFSET_W'($urandom_range(0, 12));
        sc[i].count = COUNT_W'($urandom_range(0, 12));
        if ($urandom_range(0, 7) == 0) sc[i] = strip_cfg_t'(22'($urandom));
      end
      set_timing(period, total);
      set_strips(sc[0], sc[1], sc[2], sc[3]);
      if ($urandom_range(0, 3) == 0)
        cfg_push(CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), 22'($urandom));
      cfg_flush();
      gaps_on = ($urandom_range(0, 3) != 0);
      for (int k = 0; k < 4 && sent < RANDOM_WORDS; k++) begin
        op = op_t'($urandom_range(OP_OPEN, OP_COLOR));
        send_word(op, 24'($urandom), 8'($urandom));
        n = (total + 2) * (period + 1) + 2;
        if ($urandom_range(0, 4) == 0) n = $urandom_range(1, n);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(0, 15) == 0) send_word(op_t'($urandom_range(0, 3)), 24'($urandom),
                                                    8'($urandom));
          else send_ticks(1);
        end
        sent += n + 1;
        if ($urandom_range(0, 2) == 0) begin
          s_tvalid <= 1'b0;
          do @(posedge clk); while (expected_pixels.size() != 0);
        end
      end
    end
    gaps_on = 1'b1;
    wait_idle();
  endtask

  initial begin
    reset_model();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_defaults();
    test_commands();
    test_zero_total();
    test_step_period();
    test_long_cascade();
    test_backpressure();
    test_random_traffic();
    wait_idle();
    if (error_count == 0 && expected_pixels.size() == 0) begin
      $display("led_strip_cascade_sequencer_top_tb: PASS");
    end else begin
      $display("led_strip_cascade_sequencer_top_tb: FAIL");
    end
    $finish;
  end

endmodule
